// ===== rtl/core/kmbt_pkg.sv =====
`default_nettype none

package kmbt_pkg;

    // default number of table entries
    localparam int TABLE_DEPTH_DEF = 64;

    // field widths fixed by the item format
    localparam int KEY_W   = 16;
    localparam int MOD_W   = 8;
    localparam int CMD_W   = 16;
    localparam int INDEX_W = 6;
    localparam int COUNT_W = 7;

    typedef enum logic [1:0] {
        OP_BIND   = 2'd0,
        OP_UNBIND = 2'd1,
        OP_FIND   = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_RANGE     = 2'd3
    } t_status;

    typedef struct packed {
        t_op                  op;
        logic [KEY_W-1:0]     key;
        logic [MOD_W-1:0]     modifiers;
        logic [CMD_W-1:0]     command;
        logic [INDEX_W-1:0]   index;
    } t_in_item;

    typedef struct packed {
        t_status              status;
        logic [CMD_W-1:0]     command_out;
        logic [KEY_W-1:0]     key_out;
        logic [MOD_W-1:0]     modifiers_out;
        logic [COUNT_W-1:0]   entry_count;
    } t_out_item;

    // one stored binding
    typedef struct packed {
        logic [KEY_W-1:0]     key;
        logic [MOD_W-1:0]     modifiers;
        logic [CMD_W-1:0]     command;
    } t_entry;

endpackage

`default_nettype wire

// ===== rtl/core/key_modifier_binding_table.sv =====
`default_nettype none

// channel   direction  handshake                   payload
// in        input      i_in_valid / o_in_ready     i_in_data  (kmbt_pkg::t_in_item)
// out       output     o_out_valid / i_out_ready   o_out_data (kmbt_pkg::t_out_item)
//
// bind, unbind and find scan the table one entry per cycle through the single
// read port of the entry memory; unbind then moves each later entry down one place,
// one per cycle; read fetches the entry at its index directly, without a scan.
// reset clears the entry count and control only; the entry memory is not cleared,
// entries at or above the count are never read.
// one item is taken at a time; its result sits in the output register and the next
// item may be accepted while that result waits for the downstream side.

module key_modifier_binding_table #(
    parameter int TABLE_DEPTH = kmbt_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire kmbt_pkg::t_in_item   i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output kmbt_pkg::t_out_item       o_out_data
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int IW = kmbt_pkg::INDEX_W;
    localparam int NW = kmbt_pkg::COUNT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_RDWAIT,
        S_RESP
    } t_state;

    // entry memory, one write and one read port, registered read data
    kmbt_pkg::t_entry r_mem [TABLE_DEPTH];
    kmbt_pkg::t_entry r_rdata;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    kmbt_pkg::t_entry mem_wdata;
    logic             mem_re;
    logic [AW-1:0]    mem_raddr;

    t_state                          r_state, n_state;
    kmbt_pkg::t_op                   r_op, n_op;
    logic [kmbt_pkg::KEY_W-1:0]      r_key, n_key;
    logic [kmbt_pkg::MOD_W-1:0]      r_mod, n_mod;
    logic [kmbt_pkg::CMD_W-1:0]      r_cmd, n_cmd;
    logic [CW-1:0]                   r_count, n_count;
    logic [CW-1:0]                   r_ptr, n_ptr;
    logic                            r_pend, n_pend;
    logic [AW-1:0]                   r_paddr, n_paddr;
    kmbt_pkg::t_status               r_status, n_status;
    logic [kmbt_pkg::CMD_W-1:0]      r_res_cmd, n_res_cmd;
    logic [kmbt_pkg::KEY_W-1:0]      r_res_key, n_res_key;
    logic [kmbt_pkg::MOD_W-1:0]      r_res_mod, n_res_mod;
    logic                            r_out_valid, n_out_valid;
    kmbt_pkg::t_out_item             r_out, n_out;

    logic                            hit;
    logic                            more;
    logic [CW+IW-1:0]                idx_ext;
    logic [CW+IW-1:0]                cnt_cmp;
    logic [AW+IW-1:0]                idx_addr;
    logic [CW+NW-1:0]                cnt_out;

    // memory ports
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    // compare of the entry read last cycle, and widened index and count
    assign hit      = r_pend && (r_rdata.key == r_key) && (r_rdata.modifiers == r_mod);
    assign more     = (r_ptr < r_count);
    assign idx_ext  = {{CW{1'b0}}, i_in_data.index};
    assign cnt_cmp  = {{IW{1'b0}}, r_count};
    assign idx_addr = {{AW{1'b0}}, i_in_data.index};
    assign cnt_out  = {{NW{1'b0}}, r_count};

    // next state and memory control
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_key       = r_key;
        n_mod       = r_mod;
        n_cmd       = r_cmd;
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_pend      = 1'b0;
        n_paddr     = r_paddr;
        n_status    = r_status;
        n_res_cmd   = r_res_cmd;
        n_res_key   = r_res_key;
        n_res_mod   = r_res_mod;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        mem_we      = 1'b0;
        mem_waddr   = r_paddr;
        mem_wdata   = '{key: r_key, modifiers: r_mod, command: r_cmd};
        mem_re      = 1'b0;
        mem_raddr   = r_ptr[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op      = i_in_data.op;
                    n_key     = i_in_data.key;
                    n_mod     = i_in_data.modifiers;
                    n_cmd     = i_in_data.command;
                    n_ptr     = '0;
                    n_status  = kmbt_pkg::ST_OK;
                    n_res_cmd = '0;
                    n_res_key = '0;
                    n_res_mod = '0;
                    if (i_in_data.op == kmbt_pkg::OP_READ) begin
                        if (idx_ext < cnt_cmp) begin
                            mem_re    = 1'b1;
                            mem_raddr = idx_addr[AW-1:0];
                            n_state   = S_RDWAIT;
                        end else begin
                            n_status = kmbt_pkg::ST_RANGE;
                            n_state  = S_RESP;
                        end
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end

            S_SCAN: begin
                if (hit) begin
                    case (r_op)
                        kmbt_pkg::OP_BIND: begin
                            // existing pair: rewrite the command in place
                            mem_we    = 1'b1;
                            mem_waddr = r_paddr;
                            n_state   = S_RESP;
                        end
                        kmbt_pkg::OP_UNBIND: begin
                            n_ptr   = CW'(r_paddr) + CW'(1);
                            n_state = S_SHIFT;
                        end
                        default: begin
                            n_res_cmd = r_rdata.command;
                            n_state   = S_RESP;
                        end
                    endcase
                end else if (more) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_ptr[AW-1:0];
                    n_paddr   = r_ptr[AW-1:0];
                    n_pend    = 1'b1;
                    n_ptr     = r_ptr + CW'(1);
                end else if (!r_pend || !hit) begin
                    n_state = S_RESP;
                    if (r_op == kmbt_pkg::OP_BIND) begin
                        if (r_count >= CW'(TABLE_DEPTH)) begin
                            n_status = kmbt_pkg::ST_FULL;
                        end else begin
                            // append at the end
                            mem_we    = 1'b1;
                            mem_waddr = r_count[AW-1:0];
                            n_count   = r_count + CW'(1);
                        end
                    end else begin
                        n_status = kmbt_pkg::ST_NOT_FOUND;
                    end
                end
            end

            S_SHIFT: begin
                // move the entry read last cycle down one place
                if (r_pend) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_paddr - AW'(1);
                    mem_wdata = r_rdata;
                end
                if (more) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_ptr[AW-1:0];
                    n_paddr   = r_ptr[AW-1:0];
                    n_pend    = 1'b1;
                    n_ptr     = r_ptr + CW'(1);
                end else if (!r_pend) begin
                    n_count = r_count - CW'(1);
                    n_state = S_RESP;
                end
            end

            S_RDWAIT: begin
                n_res_cmd = r_rdata.command;
                n_res_key = r_rdata.key;
                n_res_mod = r_rdata.modifiers;
                n_state   = S_RESP;
            end

            S_RESP: begin
                // load the output register once it is free
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid         = 1'b1;
                    n_out.status        = r_status;
                    n_out.command_out   = r_res_cmd;
                    n_out.key_out       = r_res_key;
                    n_out.modifiers_out = r_res_mod;
                    n_out.entry_count   = cnt_out[NW-1:0];
                    n_state             = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_key       <= n_key;
            r_mod       <= n_mod;
            r_cmd       <= n_cmd;
            r_count     <= n_count;
            r_ptr       <= n_ptr;
            r_pend      <= n_pend;
            r_paddr     <= n_paddr;
            r_status    <= n_status;
            r_res_cmd   <= n_res_cmd;
            r_res_key   <= n_res_key;
            r_res_mod   <= n_res_mod;
            r_out_valid <= n_out_valid;
            r_out       <= n_out;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // count stays within the table
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("entry count above table depth");

    // one item at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second item taken while busy");

    // count moves only as an operation completes
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |-> (r_state == S_RESP))
        else $error("entry count changed outside completion");

    // no memory write while idle
    a_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state != S_IDLE))
        else $error("memory write while idle");

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int DEPTH        = kmbt_pkg::TABLE_DEPTH_DEF;
    localparam int KEY_W        = kmbt_pkg::KEY_W;
    localparam int MOD_W        = kmbt_pkg::MOD_W;
    localparam int CMD_W        = kmbt_pkg::CMD_W;
    localparam int INDEX_W      = kmbt_pkg::INDEX_W;
    localparam int COUNT_W      = kmbt_pkg::COUNT_W;
    localparam int POOL_SIZE    = 80;
    localparam int MIX_LEN      = 70;
    localparam int IDLE_PCT     = 24;
    localparam int QUIET_LO     = 250;
    localparam int QUIET_HI     = 350;
    localparam int HOLD_AT      = 400;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 200;
    localparam int LIMIT_CYCLES = 600000;

    typedef enum int {
        PH_MIX,
        PH_FILL,
        PH_DRAIN
    } t_phase;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    kmbt_pkg::t_in_item  in_data   = '0;
    logic                in_ready;
    logic                out_valid;
    logic                out_ready = 1'b0;
    kmbt_pkg::t_out_item out_data;

    key_modifier_binding_table #(
        .TABLE_DEPTH(DEPTH)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data)
    );

    // stimulus and expected results
    kmbt_pkg::t_in_item  pending_ops[$];
    kmbt_pkg::t_out_item expected_results[$];

    // shadow copy of the binding table
    kmbt_pkg::t_entry shadow_tbl[DEPTH];
    int               shadow_count = 0;

    // pairs that the random part keeps returning to, so lookups hit
    logic [KEY_W-1:0] pool_key[POOL_SIZE];
    logic [MOD_W-1:0] pool_mod[POOL_SIZE];

    int                  cycles     = 0;
    int                  n_accepted = 0;
    int                  n_results  = 0;
    int                  n_errors   = 0;
    int                  n_full     = 0;
    int                  n_miss     = 0;
    int                  n_range    = 0;
    int                  peak_count = 0;
    int                  hold_left  = 0;
    bit                  hold_done  = 1'b0;
    kmbt_pkg::t_out_item predicted;
    kmbt_pkg::t_out_item want;

    // position of the matching pair, or -1
    function automatic int find_slot(logic [KEY_W-1:0] k, logic [MOD_W-1:0] m);
        for (int i = 0; i < shadow_count; i++) begin
            if (shadow_tbl[i].key == k && shadow_tbl[i].modifiers == m) begin
                return i;
            end
        end
        return -1;
    endfunction

    // apply one operation to the shadow table and form its result
    function automatic kmbt_pkg::t_out_item apply_binding_op(kmbt_pkg::t_in_item it);
        kmbt_pkg::t_out_item res;
        int                  pos;
        res        = '0;
        res.status = kmbt_pkg::ST_OK;
        pos        = find_slot(it.key, it.modifiers);
        case (it.op)
            kmbt_pkg::OP_BIND: begin
                if (pos >= 0) begin
                    shadow_tbl[pos].command = it.command;
                end else if (shadow_count >= DEPTH) begin
                    res.status = kmbt_pkg::ST_FULL;
                end else begin
                    shadow_tbl[shadow_count].key       = it.key;
                    shadow_tbl[shadow_count].modifiers = it.modifiers;
                    shadow_tbl[shadow_count].command   = it.command;
                    shadow_count++;
                end
            end
            kmbt_pkg::OP_UNBIND: begin
                if (pos >= 0) begin
                    // close the gap, keeping order
                    for (int i = pos; i + 1 < shadow_count; i++) begin
                        shadow_tbl[i] = shadow_tbl[i + 1];
                    end
                    shadow_count--;
                end else begin
                    res.status = kmbt_pkg::ST_NOT_FOUND;
                end
            end
            kmbt_pkg::OP_FIND: begin
                if (pos >= 0) begin
                    res.command_out = shadow_tbl[pos].command;
                end else begin
                    res.status = kmbt_pkg::ST_NOT_FOUND;
                end
            end
            kmbt_pkg::OP_READ: begin
                if (int'(it.index) < shadow_count) begin
                    res.command_out   = shadow_tbl[it.index].command;
                    res.key_out       = shadow_tbl[it.index].key;
                    res.modifiers_out = shadow_tbl[it.index].modifiers;
                end else begin
                    res.status = kmbt_pkg::ST_RANGE;
                end
            end
        endcase
        res.entry_count = COUNT_W'(shadow_count);
        return res;
    endfunction

    task automatic queue_op(kmbt_pkg::t_op op, logic [KEY_W-1:0] k, logic [MOD_W-1:0] m,
                            logic [CMD_W-1:0] c, logic [INDEX_W-1:0] ix);
        kmbt_pkg::t_in_item it;
        it.op        = op;
        it.key       = k;
        it.modifiers = m;
        it.command   = c;
        it.index     = ix;
        pending_ops.push_back(it);
    endtask

    // pair from the pool pool_pct percent of the time, else fully random
    task automatic queue_random(kmbt_pkg::t_op op, int pool_pct);
        int               p;
        logic [KEY_W-1:0] k;
        logic [MOD_W-1:0] m;
        logic [INDEX_W-1:0] ix;
        p = $urandom_range(POOL_SIZE - 1, 0);
        if ($urandom_range(99, 0) < pool_pct) begin
            k = pool_key[p];
            m = pool_mod[p];
        end else begin
            k = KEY_W'($urandom);
            m = MOD_W'($urandom);
        end
        if ($urandom_range(1, 0) != 0) begin
            ix = INDEX_W'($urandom_range(15, 0));
        end else begin
            ix = INDEX_W'($urandom_range(63, 0));
        end
        queue_op(op, k, m, CMD_W'($urandom), ix);
    endtask

    // clock
    initial begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles++;
    end

    // driver: predict on each accepted transfer, then offer the next item
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                predicted = apply_binding_op(in_data);
                expected_results.push_back(predicted);
                n_accepted++;
                case (predicted.status)
                    kmbt_pkg::ST_FULL:      n_full++;
                    kmbt_pkg::ST_NOT_FOUND: n_miss++;
                    kmbt_pkg::ST_RANGE:     n_range++;
                    default:                ;
                endcase
                if (int'(predicted.entry_count) > peak_count) begin
                    peak_count = int'(predicted.entry_count);
                end
            end
            if (!in_valid || in_ready) begin
                if (pending_ops.size() != 0 &&
                    ((n_accepted >= QUIET_LO && n_accepted < QUIET_HI) ||
                     $urandom_range(99, 0) >= IDLE_PCT)) begin
                    in_valid <= 1'b1;
                    in_data  <= pending_ops.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check each result transfer, then pick the next ready
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                n_results++;
                if (expected_results.size() == 0) begin
                    $error("result with nothing expected: status %0d, entry_count %0d",
                           out_data.status, out_data.entry_count);
                    n_errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (out_data.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, out_data.status);
                        n_errors++;
                    end
                    if (out_data.command_out !== want.command_out) begin
                        $error("command_out: expected %0h, got %0h",
                               want.command_out, out_data.command_out);
                        n_errors++;
                    end
                    if (out_data.key_out !== want.key_out) begin
                        $error("key_out: expected %0h, got %0h", want.key_out, out_data.key_out);
                        n_errors++;
                    end
                    if (out_data.modifiers_out !== want.modifiers_out) begin
                        $error("modifiers_out: expected %0h, got %0h",
                               want.modifiers_out, out_data.modifiers_out);
                        n_errors++;
                    end
                    if (out_data.entry_count !== want.entry_count) begin
                        $error("entry_count: expected %0d, got %0d",
                               want.entry_count, out_data.entry_count);
                        n_errors++;
                    end
                end
            end
            // one long hold-off so the block backs up into its input
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (!hold_done && n_results >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                out_ready <= 1'b0;
            end else begin
                out_ready <= (n_results >= QUIET_LO && n_results < QUIET_HI) ||
                             ($urandom_range(99, 0) >= IDLE_PCT);
            end
        end
    end

    // stimulus, reset and end of run
    initial begin
        int     r;
        int     p;
        int     j;
        int     tmp;
        bit     fresh;
        int     order[POOL_SIZE];
        t_phase plan[7];

        // pool with the extremes and some pairs that share a key
        pool_key[0] = '0;
        pool_mod[0] = '0;
        pool_key[1] = '1;
        pool_mod[1] = '1;
        pool_key[2] = '1;
        pool_mod[2] = 8'h7f;
        pool_key[3] = 16'hfffe;
        pool_mod[3] = '1;
        for (p = 4; p < POOL_SIZE; p++) begin
            do begin
                if ($urandom_range(3, 0) == 0) begin
                    pool_key[p] = pool_key[$urandom_range(p - 1, 0)];
                end else begin
                    pool_key[p] = KEY_W'($urandom);
                end
                pool_mod[p] = MOD_W'($urandom);
                fresh = 1'b1;
                for (j = 0; j < p; j++) begin
                    if (pool_key[j] == pool_key[p] && pool_mod[j] == pool_mod[p]) begin
                        fresh = 1'b0;
                    end
                end
            end while (!fresh);
        end

        // directed: empty table, extremes, rebind, misses, shift on unbind
        queue_op(kmbt_pkg::OP_READ,   16'h0000, 8'h00, 16'h0000, 6'd0);
        queue_op(kmbt_pkg::OP_READ,   16'h0000, 8'h00, 16'h0000, 6'd63);
        queue_op(kmbt_pkg::OP_FIND,   16'h0000, 8'h00, 16'h0000, 6'd0);
        queue_op(kmbt_pkg::OP_UNBIND, 16'hffff, 8'hff, 16'h0000, 6'd0);
        queue_op(kmbt_pkg::OP_BIND,   16'h0000, 8'h00, 16'h0000, 6'd0);
        queue_op(kmbt_pkg::OP_BIND,   16'hffff, 8'hff, 16'hffff, 6'd63);
        queue_op(kmbt_pkg::OP_BIND,   16'hffff, 8'h7f, 16'h1234, 6'd0);
        queue_op(kmbt_pkg::OP_BIND,   16'hfffe, 8'hff, 16'h5678, 6'd0);
        queue_op(kmbt_pkg::OP_FIND,   16'hffff, 8'hff, 16'h0000, 6'd0);
        queue_op(kmbt_pkg::OP_FIND,   16'h0000, 8'h00, 16'hffff, 6'd0);
        queue_op(kmbt_pkg::OP_FIND,   16'hffff, 8'hfe, 16'h0000, 6'd0);
        queue_op(kmbt_pkg::OP_BIND,   16'hffff, 8'hff, 16'h0001, 6'd0);
        queue_op(kmbt_pkg::OP_FIND,   16'hffff, 8'hff, 16'h0000, 6'd0);
        queue_op(kmbt_pkg::OP_READ,   16'h0000, 8'h00, 16'h0000, 6'd0);
        queue_op(kmbt_pkg::OP_READ,   16'h0000, 8'h00, 16'h0000, 6'd3);
        queue_op(kmbt_pkg::OP_READ,   16'h0000, 8'h00, 16'h0000, 6'd4);
        queue_op(kmbt_pkg::OP_UNBIND, 16'h0000, 8'h00, 16'h0000, 6'd0);
        queue_op(kmbt_pkg::OP_READ,   16'h0000, 8'h00, 16'h0000, 6'd0);
        queue_op(kmbt_pkg::OP_READ,   16'h0000, 8'h00, 16'h0000, 6'd2);
        queue_op(kmbt_pkg::OP_UNBIND, 16'h0000, 8'h00, 16'h0000, 6'd0);
        queue_op(kmbt_pkg::OP_UNBIND, 16'hfffe, 8'hff, 16'h0000, 6'd0);
        queue_op(kmbt_pkg::OP_READ,   16'h0000, 8'h00, 16'h0000, 6'd2);
        queue_op(kmbt_pkg::OP_FIND,   16'hffff, 8'h7f, 16'h0000, 6'd0);

        // random: mixed traffic, filling past full, draining in random order
        plan = '{PH_MIX, PH_FILL, PH_MIX, PH_DRAIN, PH_MIX, PH_FILL, PH_DRAIN};
        foreach (plan[ph]) begin
            case (plan[ph])
                PH_MIX: begin
                    for (j = 0; j < MIX_LEN; j++) begin
                        r = $urandom_range(99, 0);
                        queue_random(kmbt_pkg::t_op'(r < 35 ? kmbt_pkg::OP_BIND :
                                                     r < 55 ? kmbt_pkg::OP_UNBIND :
                                                     r < 80 ? kmbt_pkg::OP_FIND :
                                                              kmbt_pkg::OP_READ), 85);
                    end
                end
                PH_FILL: begin
                    for (p = 0; p < POOL_SIZE; p++) begin
                        queue_op(kmbt_pkg::OP_BIND, pool_key[p], pool_mod[p],
                                 CMD_W'($urandom), INDEX_W'($urandom));
                        if ($urandom_range(3, 0) == 0) begin
                            queue_random(kmbt_pkg::t_op'($urandom_range(1, 0) != 0 ?
                                                         kmbt_pkg::OP_FIND :
                                                         kmbt_pkg::OP_READ), 90);
                        end
                    end
                    // new pairs against the full table, rebind, last slot
                    repeat (3) queue_random(kmbt_pkg::OP_BIND, 0);
                    queue_op(kmbt_pkg::OP_BIND, pool_key[5], pool_mod[5],
                             CMD_W'($urandom), 6'd0);
                    queue_op(kmbt_pkg::OP_READ, 16'h0000, 8'h00, 16'h0000, 6'd63);
                end
                PH_DRAIN: begin
                    for (p = 0; p < POOL_SIZE; p++) begin
                        order[p] = p;
                    end
                    for (p = POOL_SIZE - 1; p > 0; p--) begin
                        j        = $urandom_range(p, 0);
                        tmp      = order[p];
                        order[p] = order[j];
                        order[j] = tmp;
                    end
                    for (p = 0; p < POOL_SIZE; p++) begin
                        queue_op(kmbt_pkg::OP_UNBIND, pool_key[order[p]], pool_mod[order[p]],
                                 CMD_W'($urandom), INDEX_W'($urandom));
                        if ($urandom_range(3, 0) == 0) begin
                            queue_random(kmbt_pkg::t_op'($urandom_range(1, 0) != 0 ?
                                                         kmbt_pkg::OP_FIND :
                                                         kmbt_pkg::OP_READ), 90);
                        end
                    end
                end
                default: ;
            endcase
        end

        // reset
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // wait for every transfer and result, sampled away from the active edge
        while ((pending_ops.size() != 0 || in_valid || expected_results.size() != 0) &&
               cycles < LIMIT_CYCLES) begin
            @(negedge clk);
        end

        if (cycles >= LIMIT_CYCLES) begin
            $display("key_modifier_binding_table test failed");
        end else begin
            repeat (TAIL_CYCLES) @(negedge clk);
            if (expected_results.size() != 0) begin
                $error("%0d expected results never arrived", expected_results.size());
                n_errors++;
            end
            $display("covered %0d operations and %0d results, table peaked at %0d entries",
                     n_accepted, n_results, peak_count);
            $display("binds refused on a full table %0d, misses %0d, out-of-range reads %0d",
                     n_full, n_miss, n_range);
            if (n_errors == 0) begin
                $display("key_modifier_binding_table test passed");
            end else begin
                $display("key_modifier_binding_table test failed");
            end
        end
        $finish;
    end

endmodule
